// File: hdl/sdt_pkg.sv
// Shared types and constants of the shape derivative transform.
package sdt_pkg;

  // Number of reference and physical directions.
  localparam int NUM_DIRS = 3;
  // Number of map entries per point.
  localparam int MAP_ENTRIES = 9;
  // Number of distinct Hessian entries.
  localparam int NUM_PAIRS = 6;

  // Mode code of a transform request; lower codes load one map entry.
  localparam logic [3:0] MODE_TRANSFORM = 4'd9;

  // Dimension codes.
  localparam logic [1:0] DIM_TWO   = 2'd2;
  localparam logic [1:0] DIM_THREE = 2'd3;

  // Physical direction pairs of the Hessian entries xx, xy, xz, yy, yz, zz.
  localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_B [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [31:0] word_t;

  // Inverse map of one point, indexed [reference row][physical column].
  typedef word_t [NUM_DIRS-1:0][NUM_DIRS-1:0] mat_t;

  // One request.
  typedef struct packed {
    logic [3:0] mode;
    logic [5:0] point_index;
    word_t      map_value;
    word_t      d_xi;
    word_t      d_eta;
    word_t      d_zeta;
    word_t      d2_xixi;
    word_t      d2_xieta;
    word_t      d2_xizeta;
    word_t      d2_etaeta;
    word_t      d2_etazeta;
    word_t      d2_zetazeta;
  } item_t;

  // One result.
  typedef struct packed {
    word_t grad_x;
    word_t grad_y;
    word_t grad_z;
    word_t hess_xx;
    word_t hess_xy;
    word_t hess_xz;
    word_t hess_yy;
    word_t hess_yz;
    word_t hess_zz;
  } result_t;

  // Control of the first stage as seen by the arithmetic pipeline.
  typedef struct packed {
    logic       valid;
    logic       in_range;
    logic [1:0] dimension;
  } s1_ctrl_t;

endpackage

// File: hdl/sdt_map_bank.sv
// One bank of the map store: one write port, one registered read port.
module sdt_map_bank #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sdt_datapath.sv
// Arithmetic pipeline of the transform: products, sums, rounding and saturation.
module sdt_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  sdt_pkg::s1_ctrl_t ctrl,
  input  sdt_pkg::item_t    item,
  input  sdt_pkg::mat_t     map,
  output logic              take,
  output logic              result_valid,
  input  logic              result_stall,
  output sdt_pkg::result_t  result
);

  localparam int ND    = sdt_pkg::NUM_DIRS;
  localparam int NP    = sdt_pkg::NUM_PAIRS;
  localparam int PW    = 64;
  localparam int SW    = 66;
  localparam int SPLIT = 33;
  localparam int HW    = 102;

  // Rounds to nearest with ties upward by k bits, then saturates to 32 bits.
  function automatic logic [31:0] round_sat(input logic signed [HW-1:0] v,
                                            input int k);
    logic signed [HW-1:0] rnd;
    logic signed [HW-1:0] s;
    begin
      rnd = (HW'(1) << k) >> 1;
      s   = (v + rnd) >>> k;
      if ((&s[HW-1:31]) || !(|s[HW-1:31])) begin
        round_sat = s[31:0];
      end else if (s[HW-1]) begin
        round_sat = 32'h8000_0000;
      end else begin
        round_sat = 32'h7FFF_FFFF;
      end
    end
  endfunction

  // Stage enables; a stage moves when it is empty or its successor moves.
  logic v2, v3, v4, v5;
  logic en2, en3, en4, en5, en_out;

  assign en_out = !result_valid || !result_stall;
  assign en5    = !v5 || en_out;
  assign en4    = !v4 || en5;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign take   = en2;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en2)    v2           <= ctrl.valid;
      if (en3)    v3           <= v2;
      if (en4)    v4           <= v3;
      if (en5)    v5           <= v4;
      if (en_out) result_valid <= v5;
    end
  end

  // Masking of the map: inactive rows and columns and absent points read zero.
  logic [ND-1:0]         row_on;
  logic [ND-1:0]         col_on;
  sdt_pkg::mat_t         m_eff;
  sdt_pkg::word_t [ND-1:0]         dv;
  sdt_pkg::word_t [ND-1:0][ND-1:0] hm;

  always_comb begin
    row_on[0] = 1'b1;
    row_on[1] = (ctrl.dimension == sdt_pkg::DIM_TWO) ||
                (ctrl.dimension == sdt_pkg::DIM_THREE);
    row_on[2] = (ctrl.dimension == sdt_pkg::DIM_THREE);
    col_on[0] = 1'b1;
    col_on[1] = row_on[1];
    col_on[2] = row_on[1];
    for (int r = 0; r < ND; r++) begin
      for (int a = 0; a < ND; a++) begin
        m_eff[r][a] = (ctrl.in_range && row_on[r] && col_on[a]) ? map[r][a] : '0;
      end
    end
    dv[0] = item.d_xi;
    dv[1] = item.d_eta;
    dv[2] = item.d_zeta;
    hm[0][0] = item.d2_xixi;
    hm[0][1] = item.d2_xieta;
    hm[0][2] = item.d2_xizeta;
    hm[1][0] = item.d2_xieta;
    hm[1][1] = item.d2_etaeta;
    hm[1][2] = item.d2_etazeta;
    hm[2][0] = item.d2_xizeta;
    hm[2][1] = item.d2_etazeta;
    hm[2][2] = item.d2_zetazeta;
  end

  // Stage 2: gradient products and the products of Hessian times map.
  logic signed [PW-1:0] gp [ND][ND];
  logic signed [PW-1:0] tp [ND][ND][ND];
  sdt_pkg::mat_t        m2;

  always_ff @(posedge clk) begin
    if (en2) begin
      m2 <= m_eff;
      for (int a = 0; a < ND; a++) begin
        for (int r = 0; r < ND; r++) begin
          gp[a][r] <= dv[r] * m_eff[r][a];
        end
      end
      for (int r = 0; r < ND; r++) begin
        for (int b = 0; b < ND; b++) begin
          for (int s = 0; s < ND; s++) begin
            tp[r][b][s] <= hm[r][s] * m_eff[s][b];
          end
        end
      end
    end
  end

  // Stage 3: exact gradient sums and intermediate T[r][b] = sum_s H[r][s]*M[s][b].
  logic signed [SW-1:0] gs [ND];
  logic signed [SW-1:0] ts [ND][ND];
  sdt_pkg::mat_t        m3;

  always_ff @(posedge clk) begin
    if (en3) begin
      m3 <= m2;
      for (int a = 0; a < ND; a++) begin
        gs[a] <= SW'(gp[a][0]) + SW'(gp[a][1]) + SW'(gp[a][2]);
      end
      for (int r = 0; r < ND; r++) begin
        for (int b = 0; b < ND; b++) begin
          ts[r][b] <= SW'(tp[r][b][0]) + SW'(tp[r][b][1]) + SW'(tp[r][b][2]);
        end
      end
    end
  end

  // Stage 4: gradient rounding, and M[r][a]*T[r][b] split into low and high parts.
  logic [31:0]          g4 [ND];
  logic signed [65:0]   pl [NP][ND];
  logic signed [64:0]   ph [NP][ND];

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int a = 0; a < ND; a++) begin
        g4[a] <= round_sat(HW'(gs[a]), FRAC_BITS);
      end
      for (int k = 0; k < NP; k++) begin
        for (int r = 0; r < ND; r++) begin
          pl[k][r] <= m3[r][sdt_pkg::PAIR_A[k]] *
                      $signed({1'b0, ts[r][sdt_pkg::PAIR_B[k]][SPLIT-1:0]});
          ph[k][r] <= m3[r][sdt_pkg::PAIR_A[k]] *
                      $signed(ts[r][sdt_pkg::PAIR_B[k]][SW-1:SPLIT]);
        end
      end
    end
  end

  // Stage 5: exact Hessian sums.
  logic [31:0]          g5 [ND];
  logic signed [HW-1:0] hs [NP];
  logic signed [HW-1:0] hs_next [NP];

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      hs_next[k] = '0;
      for (int r = 0; r < ND; r++) begin
        hs_next[k] = hs_next[k] + ($signed(HW'(ph[k][r])) <<< SPLIT) +
                     $signed(HW'(pl[k][r]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int a = 0; a < ND; a++) begin
        g5[a] <= g4[a];
      end
      for (int k = 0; k < NP; k++) begin
        hs[k] <= hs_next[k];
      end
    end
  end

  // Output register: Hessian rounding and saturation.
  always_ff @(posedge clk) begin
    if (en_out) begin
      result.grad_x  <= g5[0];
      result.grad_y  <= g5[1];
      result.grad_z  <= g5[2];
      result.hess_xx <= round_sat(hs[0], 2 * FRAC_BITS);
      result.hess_xy <= round_sat(hs[1], 2 * FRAC_BITS);
      result.hess_xz <= round_sat(hs[2], 2 * FRAC_BITS);
      result.hess_yy <= round_sat(hs[3], 2 * FRAC_BITS);
      result.hess_yz <= round_sat(hs[4], 2 * FRAC_BITS);
      result.hess_zz <= round_sat(hs[5], 2 * FRAC_BITS);
    end
  end

endmodule

// File: hdl/shape_derivative_transform.sv
// Top level of the shape derivative transform: map store, first stage, pipeline.
//
// Requests arrive on item (item_valid, item_stall). A request with mode 0 to 8
// writes one inverse-map entry of point point_index (row mode/3, column
// mode%3); it produces no result. A request with mode 9 reads the nine map
// entries of its point and produces one result on result (result_valid,
// result_stall): the physical gradient and the symmetric Hessian, each Q16.16,
// rounded once and saturated. Other modes are dropped.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets dimension;
// cfg_ready is always high. Write it only while no request is in flight.
// Path: a transform passes the first stage, stages 2 to 5 and the output
// register. Throughput is one request per cycle while the result side does
// not stall; the nine map banks each do one write or one read per cycle, and
// a load is visible to a transform accepted in the very next cycle.
// Reset clears all valid bits and sets dimension to 3. The map store is not
// cleared; a point must be loaded before it is transformed.
// When the receiver stalls, the result holds, empty stages behind it still
// fill, and item_stall rises only once the first stage is occupied.
module shape_derivative_transform #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sdt_pkg::item_t   item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data,
  output logic             result_valid,
  input  logic             result_stall,
  output sdt_pkg::result_t result
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NE = sdt_pkg::MAP_ENTRIES;
  localparam int ND = sdt_pkg::NUM_DIRS;

  logic       accept;
  logic       take;
  logic       en1;
  logic       v1;
  logic       in_range;
  logic       in_range1;
  logic       is_transform;
  logic [1:0] dimension;
  logic [AW-1:0]   addr;
  sdt_pkg::item_t  item1;
  logic [31:0]     rdata [NE];
  sdt_pkg::mat_t   map1;
  sdt_pkg::s1_ctrl_t ctrl1;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= sdt_pkg::DIM_THREE;
    end else if (cfg_valid && cfg_ready) begin
      dimension <= cfg_data;
    end
  end

  // Request handshake into the first stage.
  assign en1          = !v1 || take;
  assign item_stall   = !en1;
  assign accept       = item_valid && en1;
  assign in_range     = 32'(item.point_index) < MAX_POINTS;
  assign addr         = AW'(item.point_index);
  assign is_transform = (item.mode == sdt_pkg::MODE_TRANSFORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= item_valid && is_transform;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item1     <= item;
      in_range1 <= in_range;
    end
  end

  // Map store: one bank per map entry, all read together by a transform.
  for (genvar j = 0; j < NE; j++) begin : g_bank
    sdt_map_bank #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .we    (accept && in_range && (item.mode == 4'(j))),
      .waddr (addr),
      .wdata (item.map_value),
      .re    (accept && is_transform),
      .raddr (addr),
      .rdata (rdata[j])
    );
  end

  always_comb begin
    for (int r = 0; r < ND; r++) begin
      for (int a = 0; a < ND; a++) begin
        map1[r][a] = rdata[r * ND + a];
      end
    end
  end

  assign ctrl1.valid     = v1;
  assign ctrl1.in_range  = in_range1;
  assign ctrl1.dimension = dimension;

  // Arithmetic pipeline and output register.
  sdt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl1),
    .item         (item1),
    .map          (map1),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: hdl/sdt_checker.sv
// Port-level checks of the shape derivative transform, bound to the top level.
module sdt_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sdt_pkg::item_t   item,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [1:0]       cfg_data,
  input logic             result_valid,
  input logic             result_stall,
  input sdt_pkg::result_t result
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A free output never back-pressures the request side.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !item_stall)
    else $error("request stalled while result side is free");

  // Configuration is always taken.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind shape_derivative_transform sdt_checker u_sdt_checker (.*);
